>>> hdl/lnct_pkg.sv
// Shared types, codes and constants of the LRU node cache tag store.
package lnct_pkg;

  // Field widths
  localparam int unsigned CFG_W  = 7;
  localparam int unsigned IDX_W  = 16;
  localparam int unsigned KEY_W  = 64;
  localparam int unsigned SLOT_W = 6;

  // Capacity register reset value and smallest active capacity
  localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;
  localparam logic [CFG_W-1:0] MIN_CAP   = 7'd16;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_CLEAR  = 2'd2
  } lnct_cmd_e;

  typedef enum logic [3:0] {
    ST_RESET,
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_CLEAR,
    ST_SEARCH,
    ST_DECIDE,
    ST_TOUCH,
    ST_EVICT,
    ST_EMIT_EV,
    ST_PLACE,
    ST_EMIT_EMPTY,
    ST_EMIT_HIT,
    ST_EMIT_NEW
  } ctl_state_e;

  typedef enum logic [2:0] {
    SCAN_CLEAR,
    SCAN_SEARCH,
    SCAN_TOUCH,
    SCAN_EVICT,
    SCAN_PLACE
  } scan_mode_e;

  typedef enum logic [1:0] {
    OUT_EMPTY,
    OUT_HIT,
    OUT_NEW,
    OUT_EVICT
  } out_kind_e;

  typedef struct packed {
    logic [1:0]       command;
    logic [IDX_W-1:0] first_x_index;
    logic [IDX_W-1:0] second_x_index;
    logic [IDX_W-1:0] first_scale_index;
    logic [IDX_W-1:0] second_scale_index;
  } lnct_in_t;

  typedef struct packed {
    logic              hit;
    logic              slot_valid;
    logic [SLOT_W-1:0] slot;
    logic              evicted_valid;
    logic [KEY_W-1:0]  victim_key;
    logic              last;
  } lnct_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       scan_start;
    scan_mode_e scan_mode;
    logic       count_dec;
    logic       out_load;
    out_kind_e  out_kind;
  } lnct_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_clear;
    logic is_lookup;
    logic is_insert;
    logic bypass;
    logic hit;
    logic need_evict;
    logic last_evict;
    logic scan_done;
    logic out_free;
  } lnct_sts_t;

endpackage

>>> hdl/lnct_ctrl.sv
// Sequencer of the tag store: orders scans, evictions and result beats.
module lnct_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lnct_pkg::lnct_sts_t sts_i,
  output lnct_pkg::lnct_ctl_t ctl_o
);
  import lnct_pkg::*;

  ctl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RESET;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RESET: state_d = ST_INIT;
      ST_INIT: begin
        if (sts_i.scan_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (sts_i.is_clear) begin
          state_d = ST_CLEAR;
        end else if ((!sts_i.is_lookup && !sts_i.is_insert) || sts_i.bypass) begin
          state_d = ST_EMIT_EMPTY;
        end else begin
          state_d = ST_SEARCH;
        end
      end
      ST_CLEAR: begin
        if (sts_i.scan_done) state_d = ST_EMIT_EMPTY;
      end
      ST_SEARCH: begin
        if (sts_i.scan_done) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts_i.hit) begin
          state_d = ST_TOUCH;
        end else if (sts_i.is_lookup) begin
          state_d = ST_EMIT_EMPTY;
        end else if (sts_i.need_evict) begin
          state_d = ST_EVICT;
        end else begin
          state_d = ST_EMIT_NEW;
        end
      end
      ST_TOUCH: begin
        if (sts_i.scan_done) state_d = ST_EMIT_HIT;
      end
      ST_EVICT: begin
        if (sts_i.scan_done) state_d = ST_EMIT_EV;
      end
      ST_EMIT_EV: begin
        if (sts_i.out_free) state_d = sts_i.last_evict ? ST_PLACE : ST_EVICT;
      end
      ST_PLACE: begin
        if (sts_i.scan_done) state_d = ST_IDLE;
      end
      ST_EMIT_EMPTY, ST_EMIT_HIT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      ST_EMIT_NEW: begin
        if (sts_i.out_free) state_d = ST_PLACE;
      end
      default: state_d = ST_RESET;
    endcase
  end

  // Outputs: start a scan on entry to a scan state, load a beat in emit states
  always_comb begin
    ctl_o            = '0;
    ctl_o.scan_mode  = SCAN_CLEAR;
    ctl_o.out_kind   = OUT_EMPTY;
    in_ready_o       = (state_q == ST_IDLE);
    ctl_o.load       = (state_q == ST_IDLE) && in_valid_i;

    if (state_d != state_q) begin
      unique case (state_d)
        ST_INIT, ST_CLEAR: begin
          ctl_o.scan_start = 1'b1;
          ctl_o.scan_mode  = SCAN_CLEAR;
        end
        ST_SEARCH: begin
          ctl_o.scan_start = 1'b1;
          ctl_o.scan_mode  = SCAN_SEARCH;
        end
        ST_TOUCH: begin
          ctl_o.scan_start = 1'b1;
          ctl_o.scan_mode  = SCAN_TOUCH;
        end
        ST_EVICT: begin
          ctl_o.scan_start = 1'b1;
          ctl_o.scan_mode  = SCAN_EVICT;
        end
        ST_PLACE: begin
          ctl_o.scan_start = 1'b1;
          ctl_o.scan_mode  = SCAN_PLACE;
        end
        default: ;
      endcase
    end

    unique case (state_q)
      ST_EMIT_EMPTY: begin
        ctl_o.out_load = sts_i.out_free;
        ctl_o.out_kind = OUT_EMPTY;
      end
      ST_EMIT_HIT: begin
        ctl_o.out_load = sts_i.out_free;
        ctl_o.out_kind = OUT_HIT;
      end
      ST_EMIT_NEW: begin
        ctl_o.out_load = sts_i.out_free;
        ctl_o.out_kind = OUT_NEW;
      end
      ST_EMIT_EV: begin
        ctl_o.out_load  = sts_i.out_free;
        ctl_o.count_dec = sts_i.out_free;
        ctl_o.out_kind  = OUT_EVICT;
      end
      default: ;
    endcase
  end

endmodule

>>> hdl/lnct_dpath.sv
// Datapath of the tag store: key and recency memories, scan engine, result register.
module lnct_dpath #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lnct_pkg::lnct_in_t         in_data_i,
  input  logic                       cfg_we_i,
  input  logic [lnct_pkg::CFG_W-1:0] cfg_data_i,
  input  lnct_pkg::lnct_ctl_t        ctl_i,
  output lnct_pkg::lnct_sts_t        sts_o,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output lnct_pkg::lnct_out_t        out_data_o
);
  import lnct_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] LastIdx = IW'(CAPACITY - 1);

  // Entry stores: key, and {valid, recency rank}
  logic [KEY_W-1:0] key_mem  [CAPACITY];
  logic [IW:0]      meta_mem [CAPACITY];

  logic [CFG_W-1:0] capacity_q;
  logic [KEY_W-1:0] key_q;
  logic [1:0]       cmd_q;
  logic [CW-1:0]    cap_q, cap_d;
  logic [CW-1:0]    count_q;

  logic             rd_busy_q;
  logic [IW-1:0]    rd_idx_q;
  scan_mode_e       mode_q;
  logic             s1_vld_q, s1_last_q;
  logic [IW-1:0]    s1_idx_q;
  logic [IW:0]      meta_rd_q;
  logic [KEY_W-1:0] key_rd_q;

  logic             hit_found_q, free_found_q, first_found_q;
  logic [IW-1:0]    hit_idx_q, hit_rank_q, free_idx_q, first_idx_q;
  logic [KEY_W-1:0] ev_key_q;

  logic             out_valid_q;
  lnct_out_t        out_q, out_d;

  logic             ent_valid, key_match, victim;
  logic [IW-1:0]    ent_rank, evict_rank, new_slot;
  logic             meta_we, key_we;
  logic [IW:0]      meta_wdata;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_data_i;
    end
  end

  // Clamp capacity: zero bypasses, small values act as the minimum, large ones as CAPACITY
  always_comb begin
    if (capacity_q == '0) begin
      cap_d = '0;
    end else if (capacity_q < MIN_CAP) begin
      cap_d = CW'(MIN_CAP);
    end else if (32'(capacity_q) > CAPACITY) begin
      cap_d = CW'(CAPACITY);
    end else begin
      cap_d = CW'(capacity_q);
    end
  end

  // Latch the item on an input beat
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      key_q <= {in_data_i.second_scale_index, in_data_i.first_scale_index,
                in_data_i.second_x_index, in_data_i.first_x_index};
      cmd_q <= in_data_i.command;
      cap_q <= cap_d;
    end
  end

  // Entry count: zero on a clear sweep, up on placement, down per eviction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctl_i.scan_start && ctl_i.scan_mode == SCAN_CLEAR) begin
      count_q <= '0;
    end else if (ctl_i.scan_start && ctl_i.scan_mode == SCAN_PLACE) begin
      // The last eviction beat and the placement share an edge: net zero
      if (!ctl_i.count_dec) count_q <= count_q + CW'(1);
    end else if (ctl_i.count_dec) begin
      count_q <= count_q - CW'(1);
    end
  end

  // Scan engine: issue one read per cycle over all entries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_busy_q <= 1'b0;
      rd_idx_q  <= '0;
      mode_q    <= SCAN_CLEAR;
      s1_vld_q  <= 1'b0;
      s1_last_q <= 1'b0;
      s1_idx_q  <= '0;
    end else begin
      if (ctl_i.scan_start) begin
        rd_busy_q <= 1'b1;
        rd_idx_q  <= '0;
        mode_q    <= ctl_i.scan_mode;
      end else if (rd_busy_q) begin
        rd_idx_q <= rd_idx_q + IW'(1);
        if (rd_idx_q == LastIdx) rd_busy_q <= 1'b0;
      end
      s1_vld_q  <= rd_busy_q;
      s1_last_q <= (rd_idx_q == LastIdx);
      s1_idx_q  <= rd_idx_q;
    end
  end

  // Memories: write back at the data stage, registered read at the scan pointer
  always_ff @(posedge clk_i) begin
    if (meta_we) meta_mem[s1_idx_q] <= meta_wdata;
    if (key_we) key_mem[s1_idx_q] <= key_q;
    meta_rd_q <= meta_mem[rd_idx_q];
    key_rd_q  <= key_mem[rd_idx_q];
  end

  assign ent_valid  = meta_rd_q[IW];
  assign ent_rank   = meta_rd_q[IW-1:0];
  assign key_match  = ent_valid && (key_rd_q == key_q);
  assign evict_rank = IW'(count_q - CW'(1));
  assign victim     = ent_valid && (ent_rank == evict_rank);
  assign new_slot   = first_found_q ? first_idx_q : free_idx_q;

  // Data stage write-back per scan mode
  always_comb begin
    meta_we    = 1'b0;
    meta_wdata = '0;
    key_we     = 1'b0;
    if (s1_vld_q) begin
      unique case (mode_q)
        SCAN_CLEAR: begin
          meta_we = 1'b1;
        end
        SCAN_TOUCH: begin
          if (s1_idx_q == hit_idx_q) begin
            meta_we    = 1'b1;
            meta_wdata = {1'b1, {IW{1'b0}}};
          end else if (ent_valid && ent_rank < hit_rank_q) begin
            meta_we    = 1'b1;
            meta_wdata = {1'b1, ent_rank + IW'(1)};
          end
        end
        SCAN_EVICT: begin
          meta_we = victim;
        end
        SCAN_PLACE: begin
          if (s1_idx_q == new_slot) begin
            meta_we    = 1'b1;
            meta_wdata = {1'b1, {IW{1'b0}}};
            key_we     = 1'b1;
          end else if (ent_valid) begin
            meta_we    = 1'b1;
            meta_wdata = {1'b1, ent_rank + IW'(1)};
          end
        end
        default: ;
      endcase
    end
  end

  // Search and eviction findings
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_found_q   <= 1'b0;
      free_found_q  <= 1'b0;
      first_found_q <= 1'b0;
      hit_idx_q     <= '0;
      hit_rank_q    <= '0;
      free_idx_q    <= '0;
      first_idx_q   <= '0;
    end else if (ctl_i.scan_start && ctl_i.scan_mode == SCAN_SEARCH) begin
      hit_found_q   <= 1'b0;
      free_found_q  <= 1'b0;
      first_found_q <= 1'b0;
    end else if (s1_vld_q) begin
      if (mode_q == SCAN_SEARCH) begin
        if (key_match && !hit_found_q) begin
          hit_found_q <= 1'b1;
          hit_idx_q   <= s1_idx_q;
          hit_rank_q  <= ent_rank;
        end
        if (!ent_valid && !free_found_q) begin
          free_found_q <= 1'b1;
          free_idx_q   <= s1_idx_q;
        end
      end
      if (mode_q == SCAN_EVICT && victim && !first_found_q) begin
        first_found_q <= 1'b1;
        first_idx_q   <= s1_idx_q;
      end
    end
  end

  // Capture the evicted key
  always_ff @(posedge clk_i) begin
    if (s1_vld_q && mode_q == SCAN_EVICT && victim) ev_key_q <= key_rd_q;
  end

  // Build a result beat
  always_comb begin
    out_d = '0;
    unique case (ctl_i.out_kind)
      OUT_EMPTY: begin
        out_d.last = 1'b1;
      end
      OUT_HIT: begin
        out_d.hit        = 1'b1;
        out_d.slot_valid = 1'b1;
        out_d.slot       = SLOT_W'(hit_idx_q);
        out_d.last       = 1'b1;
      end
      OUT_NEW: begin
        out_d.slot_valid = 1'b1;
        out_d.slot       = SLOT_W'(new_slot);
        out_d.last       = 1'b1;
      end
      OUT_EVICT: begin
        out_d.slot_valid    = 1'b1;
        out_d.slot          = SLOT_W'(new_slot);
        out_d.evicted_valid = 1'b1;
        out_d.victim_key    = ev_key_q;
        out_d.last          = (count_q == cap_q);
      end
      default: ;
    endcase
  end

  // Output register: hold a beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Status to the sequencer
  always_comb begin
    sts_o            = '0;
    sts_o.is_clear   = (cmd_q == CMD_CLEAR);
    sts_o.is_lookup  = (cmd_q == CMD_LOOKUP);
    sts_o.is_insert  = (cmd_q == CMD_INSERT);
    sts_o.bypass     = (cap_q == '0);
    sts_o.hit        = hit_found_q;
    sts_o.need_evict = (count_q >= cap_q) && (count_q != '0);
    sts_o.last_evict = (count_q == cap_q);
    sts_o.scan_done  = s1_vld_q && s1_last_q;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

>>> hdl/lru_node_cache_tags_unit.sv
// Top level of the fully associative LRU tag store for grid-node results.
// A scan visits all CAPACITY entries, one per cycle. A hit runs a search and a touch
// scan; a new key on insert runs a search, one eviction scan per evicted entry, then a
// place scan. A lookup miss runs a search only, a clear one clearing scan, bypass none.
// One item at a time; a stalled result beat stretches the item by the stall.
// After reset a clearing pass runs before the first item is taken.
module lru_node_cache_tags_unit #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  lnct_pkg::lnct_in_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output lnct_pkg::lnct_out_t        out_data_o,
  input  logic                       cfg_we_i,
  input  logic [lnct_pkg::CFG_W-1:0] cfg_data_i
);
  import lnct_pkg::*;

  lnct_ctl_t ctl;
  lnct_sts_t sts;

  // Sequencer
  lnct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // Storage and result path
  lnct_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

>>> tb/lru_node_cache_tags_unit_tb.sv
// Self-checking testbench for the LRU node cache tag store: predicts every result beat and compares it.
module lru_node_cache_tags_unit_tb;
  import lnct_pkg::*;

  localparam int unsigned SLOTS            = 64;
  localparam logic [1:0]  CMD_RSVD         = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT   = 20000;
  localparam int unsigned SETTLE_CYCLES    = 2 * (SLOTS + 1) + 16;
  localparam int unsigned HOLD_CYCLES      = 3000;
  localparam int unsigned HOLD_AFTER_BEATS = 100;
  localparam int unsigned NUM_PHASES       = 9;
  localparam int unsigned POOL_SIZE        = 256;

  // Tag store predictor and queue of expected result beats
  class node_tag_board;
    logic [KEY_W-1:0] tag_key [SLOTS];
    bit               tag_live [SLOTS];
    int unsigned      age [SLOTS];
    int unsigned      live_count;
    logic [CFG_W-1:0] cap_reg;
    lnct_out_t        expected_q [$];
    int unsigned      mismatch_count;

    function new();
      foreach (tag_live[j]) begin
        tag_live[j] = 1'b0;
        age[j]      = 0;
        tag_key[j]  = '0;
      end
      live_count     = 0;
      cap_reg        = CAP_RESET;
      mismatch_count = 0;
    endfunction

    // Map the register onto the number of entries actually kept
    function int unsigned active_cap();
      int unsigned c;
      c = cap_reg;
      if (c == 0) return 0;
      if (c < MIN_CAP) c = MIN_CAP;
      if (c > SLOTS) c = SLOTS;
      return c;
    endfunction

    function lnct_out_t make_result(bit hit_b, bit sv_b, int slot_n, bit ev_b,
                                    logic [KEY_W-1:0] gone, bit last_b);
      lnct_out_t r;
      r.hit           = hit_b;
      r.slot_valid    = sv_b;
      r.slot          = sv_b ? SLOT_W'(slot_n) : '0;
      r.evicted_valid = ev_b;
      r.victim_key    = ev_b ? gone : '0;
      r.last          = last_b;
      return r;
    endfunction

    // Append one beat to the tail of the expectation queue
    function void expect_beat(lnct_out_t r);
      expected_q.insert(expected_q.size(), r);
    endfunction

    task report_mismatch(string what, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
      mismatch_count++;
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    endtask

    // Update the store for one accepted request beat and queue its result beats
    function void note_request(lnct_in_t req);
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] gone_q [$];
      int unsigned      cap;
      int unsigned      r;
      int               found;
      int               victim;
      int               freed;
      int               slot_n;
      int               j;
      key = {req.second_scale_index, req.first_scale_index,
             req.second_x_index, req.first_x_index};
      cap = active_cap();

      // Clear drops every entry
      if (req.command == CMD_CLEAR) begin
        for (j = 0; j < SLOTS; j++) begin
          tag_live[j] = 1'b0;
          age[j]      = 0;
        end
        live_count = 0;
        expect_beat(make_result(0, 0, 0, 0, '0, 1));
        return;
      end

      // Reserved command and bypass leave the store alone
      if (req.command == CMD_RSVD || cap == 0) begin
        expect_beat(make_result(0, 0, 0, 0, '0, 1));
        return;
      end

      // Search; a hit moves the entry to the front
      found = -1;
      for (j = 0; j < SLOTS; j++) begin
        if (tag_live[j] && tag_key[j] == key) begin
          found = j;
          break;
        end
      end
      if (found >= 0) begin
        r = age[found];
        for (j = 0; j < SLOTS; j++)
          if (tag_live[j] && age[j] < r) age[j]++;
        age[found] = 0;
        expect_beat(make_result(1, 1, found, 0, '0, 1));
        return;
      end
      if (req.command == CMD_LOOKUP) begin
        expect_beat(make_result(0, 0, 0, 0, '0, 1));
        return;
      end

      // New key: evict the oldest entries until there is room
      freed = -1;
      while (live_count >= cap && live_count > 0) begin
        victim = -1;
        for (j = 0; j < SLOTS; j++)
          if (tag_live[j] && (victim < 0 || age[j] > age[victim])) victim = j;
        if (victim < 0) begin
          live_count = 0;
          break;
        end
        gone_q.insert(gone_q.size(), tag_key[victim]);
        tag_live[victim] = 1'b0;
        age[victim]      = 0;
        live_count--;
        if (freed < 0) freed = victim;
      end

      // Reuse the first freed slot, else take the lowest free one
      slot_n = freed;
      if (slot_n < 0) begin
        for (j = 0; j < SLOTS; j++) begin
          if (!tag_live[j]) begin
            slot_n = j;
            break;
          end
        end
      end
      if (slot_n < 0) begin
        expect_beat(make_result(0, 0, 0, 0, '0, 1));
        return;
      end
      for (j = 0; j < SLOTS; j++)
        if (tag_live[j]) age[j]++;
      tag_key[slot_n]  = key;
      tag_live[slot_n] = 1'b1;
      age[slot_n]      = 0;
      live_count++;

      if (gone_q.size() == 0) begin
        expect_beat(make_result(0, 1, slot_n, 0, '0, 1));
      end else begin
        foreach (gone_q[k])
          expect_beat(make_result(0, 1, slot_n, 1, gone_q[k], k == gone_q.size() - 1));
      end
    endfunction

    // Compare one result beat with the oldest expectation
    task check_response(lnct_out_t got);
      lnct_out_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("beat with nothing expected, key", got.victim_key, '0);
        return;
      end
      want = expected_q[0];
      expected_q.delete(0);
      if (got.hit !== want.hit)
        report_mismatch("hit", 64'(got.hit), 64'(want.hit));
      if (got.slot_valid !== want.slot_valid)
        report_mismatch("slot_valid", 64'(got.slot_valid), 64'(want.slot_valid));
      if (got.slot !== want.slot)
        report_mismatch("slot", 64'(got.slot), 64'(want.slot));
      if (got.evicted_valid !== want.evicted_valid)
        report_mismatch("evicted_valid", 64'(got.evicted_valid), 64'(want.evicted_valid));
      if (got.victim_key !== want.victim_key)
        report_mismatch("victim_key", got.victim_key, want.victim_key);
      if (got.last !== want.last)
        report_mismatch("last", 64'(got.last), 64'(want.last));
    endtask
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  lnct_in_t         in_data;
  logic             out_valid;
  logic             out_ready;
  lnct_out_t        out_data;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_data;

  node_tag_board    board;
  int unsigned      in_beats;
  int unsigned      out_beats;
  int unsigned      idle_cycles;
  bit               moved;
  bit               calm;
  logic [KEY_W-1:0] tag_pool [POOL_SIZE];

  // Random phases: capacity, length, key spread and command mix
  logic [CFG_W-1:0] phase_cap     [NUM_PHASES] = '{7'd1, 7'd64, 7'd20, 7'd0, 7'd127,
                                                   7'd16, 7'd37, 7'd15, 7'd64};
  int unsigned      phase_items   [NUM_PHASES] = '{50, 70, 40, 10, 110, 40, 40, 20, 30};
  int unsigned      phase_span    [NUM_PHASES] = '{24, 80, 28, 24, 200, 24, 48, 20, 80};
  int unsigned      phase_ins_pct [NUM_PHASES] = '{50, 50, 50, 50, 85, 55, 50, 50, 50};
  int unsigned      phase_clr_pct [NUM_PHASES] = '{2, 2, 2, 4, 0, 2, 2, 2, 2};

  lru_node_cache_tags_unit #(
    .CAPACITY (SLOTS)
  ) uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Sample both channels at the rising edge; count cycles without a beat
  initial begin
    in_beats    = 0;
    out_beats   = 0;
    idle_cycles = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      moved = 1'b0;
      if (out_valid && out_ready) begin
        board.check_response(out_data);
        out_beats++;
        moved = 1'b1;
      end
      if (in_valid && in_ready) begin
        board.note_request(in_data);
        in_beats++;
        moved = 1'b1;
      end
      if (moved) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: random stalls, one long hold-off, none at the end
  initial begin : receiver
    bit held_off;
    held_off  = 1'b0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (calm) begin
        out_ready = 1'b1;
        @(negedge clk);
      end else if (!held_off && in_beats >= HOLD_AFTER_BEATS) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        held_off = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
        repeat ($urandom_range(1, 40)) @(negedge clk);
      end
    end
  end

  function automatic lnct_in_t make_item(logic [1:0] cmd, logic [KEY_W-1:0] key);
    lnct_in_t item;
    item.command            = cmd;
    item.first_x_index      = key[15:0];
    item.second_x_index     = key[31:16];
    item.first_scale_index  = key[47:32];
    item.second_scale_index = key[63:48];
    return item;
  endfunction

  // Offer one request beat and hold it until accepted
  task automatic send_item(input lnct_in_t item);
    in_data  = item;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Write the capacity register while the block is idle
  task automatic set_capacity(input logic [CFG_W-1:0] value);
    cfg_we        = 1'b1;
    cfg_data      = value;
    board.cap_reg = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Drop valid, wait for every expected beat, then let the block settle
  task automatic drain_block();
    in_valid = 1'b0;
    while (board.expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Stimulus
  initial begin
    int unsigned      p;
    int unsigned      i;
    int unsigned      roll;
    int unsigned      clr;
    int unsigned      ins;
    logic [1:0]       cmd;
    logic [KEY_W-1:0] key;

    board    = new();
    calm     = 1'b0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    cfg_we   = 1'b0;
    cfg_data = '0;
    foreach (tag_pool[k]) tag_pool[k] = {$urandom, $urandom};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: extremes of the key, hits, touches, reserved command, clear
    set_capacity(7'd64);
    send_item(make_item(CMD_LOOKUP, 64'h0));
    send_item(make_item(CMD_INSERT, 64'h0));
    send_item(make_item(CMD_INSERT, '1));
    send_item(make_item(CMD_INSERT, 64'h0123_4567_89AB_CDEF));
    send_item(make_item(CMD_LOOKUP, '1));
    send_item(make_item(CMD_INSERT, 64'h0));
    send_item(make_item(CMD_RSVD, {$urandom, $urandom}));
    send_item(make_item(CMD_LOOKUP, 64'hFFFF_0000_FFFF_0000));
    send_item(make_item(CMD_INSERT, 64'h0000_FFFF_0000_FFFF));
    send_item(make_item(CMD_CLEAR, 64'h0));
    send_item(make_item(CMD_LOOKUP, '1));
    drain_block();

    // Directed: bypass leaves the store untouched by inserts and lookups; a clear still runs
    set_capacity(7'd0);
    send_item(make_item(CMD_INSERT, '1));
    send_item(make_item(CMD_LOOKUP, '1));
    send_item(make_item(CMD_CLEAR, '1));

    // Random phases over a pool of keys, with some noise keys
    for (p = 0; p < NUM_PHASES; p++) begin
      drain_block();
      set_capacity(phase_cap[p]);
      calm = (p == NUM_PHASES - 1);
      clr  = phase_clr_pct[p];
      ins  = phase_ins_pct[p];
      for (i = 0; i < phase_items[p]; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) cmd = CMD_RSVD;
        else if (roll < 3 + clr) cmd = CMD_CLEAR;
        else if (roll < 3 + clr + ins) cmd = CMD_INSERT;
        else cmd = CMD_LOOKUP;
        if ($urandom_range(0, 9) == 0) key = {$urandom, $urandom};
        else key = tag_pool[$urandom_range(0, phase_span[p] - 1)];
        if (!calm && $urandom_range(0, 2) == 0) begin
          in_valid = 1'b0;
          repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        send_item(make_item(cmd, key));
      end
    end

    drain_block();
    if (board.mismatch_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
